>>> rtl/steffensen_vector_accelerator_unit_macros.svh
// Assertion helpers shared by the accelerator RTL.
// Each macro expects clk and rst in scope.
`ifndef STEFFENSEN_VECTOR_ACCELERATOR_UNIT_MACROS_SVH
`define STEFFENSEN_VECTOR_ACCELERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define SVAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SVAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/svau_pkg.sv
`default_nettype none
package svau_pkg;

  localparam int VECTOR_LENGTH_DEF = 64;

  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int IT_W   = 16;
  localparam int THR_W  = 31;

  // config register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ITERATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD  = 1'b1;

  localparam logic [IT_W-1:0]  START_ITERATION_RST = 16'd3;
  localparam logic [THR_W-1:0] DIFF_THRESHOLD_RST  = 31'd1;

  // datapath widths
  localparam int DIFF_W = VAL_W + 1;      // a, b and their magnitudes
  localparam int DEN_W  = VAL_W + 2;      // b - a and its magnitude
  localparam int PROD_W = 2 * DIFF_W - 1; // |a| * |b| never exceeds 2^64
  localparam int QUO_W  = VAL_W + 1;      // quotient kept when no overflow
  localparam int SUM_W  = VAL_W + 3;

  // divider: restoring, a few quotient bits per stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

  // beat side information carried alongside the divider
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] nv;
    logic [VAL_W-1:0] p1;
    logic             acc;
    logic             early_sat;
    logic             early_neg;
    logic             neg;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/svau_ram.sv
`default_nettype none
module svau_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                        wdata,
  input  wire                                     re,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/svau_div.sv
`default_nettype none
`include "steffensen_vector_accelerator_unit_macros.svh"
module svau_div (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [svau_pkg::PROD_W-1:0]     in_num,
  input  wire  [svau_pkg::DEN_W-1:0]      in_den,
  input  wire  svau_pkg::side_t           in_side,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [svau_pkg::QUO_W-1:0]      out_q,
  output svau_pkg::side_t                 out_side
);

  localparam int NS = svau_pkg::DIV_STAGES;
  localparam int QW = svau_pkg::QUO_W;
  localparam int DW = svau_pkg::DEN_W;

  typedef struct packed {
    svau_pkg::side_t side;
    logic [DW-1:0]   rem;
    logic [QW-1:0]   num;
    logic [DW-1:0]   den;
    logic [QW-1:0]   q;
  } div_stage_t;

  div_stage_t st  [NS];
  div_stage_t src [NS];
  div_stage_t nxt [NS];
  logic [NS-1:0] v;
  logic [NS:0]   en;

  // top bits seed the remainder; low bits are shifted in one per step
  always_comb begin
    src[0].side = in_side;
    src[0].rem  = {2'b00, in_num[svau_pkg::PROD_W-1:QW]};
    src[0].num  = in_num[QW-1:0];
    src[0].den  = in_den;
    src[0].q    = '0;
  end

  assign en[NS] = ~out_stall;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k > 0) begin : g_src
      assign src[k] = st[k-1];
    end

    always_comb begin : step
      div_stage_t w;
      logic [DW:0] t;
      w = src[k];
      t = '0;
      for (int s = 0; s < svau_pkg::DIV_STEPS; s++) begin
        if (k * svau_pkg::DIV_STEPS + s < QW) begin
          t = {w.rem, w.num[QW-1]};
          w.num = {w.num[QW-2:0], 1'b0};
          if (t >= {1'b0, w.den}) begin
            t = t - {1'b0, w.den};
            w.rem = t[DW-1:0];
            w.q = {w.q[QW-2:0], 1'b1};
          end else begin
            w.rem = t[DW-1:0];
            w.q = {w.q[QW-2:0], 1'b0};
          end
        end
      end
      nxt[k] = w;
    end

    assign en[k] = ~v[k] | en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = v[NS-1];
  assign out_q     = st[NS-1].q;
  assign out_side  = st[NS-1].side;

  `SVAU_ASSERT_NEXT(a_div_hold, v[NS-1] && out_stall, v[NS-1] && $stable(st[NS-1].q), "div output lost under stall")
  `SVAU_ASSERT_NEXT(a_div_take, in_valid && !in_stall, v[0], "div first stage missed a beat")

endmodule
`default_nettype wire

>>> rtl/steffensen_vector_accelerator_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  element_index, new_value, iteration
// result    out        out_valid/out_stall  result_index, result_value, accelerated, saturated
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// One beat in and one beat out per cycle while no stall holds the flow; a beat
// passes S1 to S6, the divider stages and the output register to the result
// beat (11 divider stages of three quotient bits each at the default widths).
// After rst the history memory is swept to zero, one entry a cycle, so the
// input stalls until the sweep ends; config writes are taken meanwhile.
// Stalls ripple back stage by stage: a bubble anywhere lets the input move.
`default_nettype none
`include "steffensen_vector_accelerator_unit_macros.svh"
module steffensen_vector_accelerator_unit #(
  parameter int VECTOR_LENGTH = svau_pkg::VECTOR_LENGTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // config
  input  wire                                cfg_wr_en,
  input  wire  [svau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [svau_pkg::THR_W-1:0]         cfg_data,
  // input beats
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [svau_pkg::IDX_W-1:0]         element_index,
  input  wire  signed [svau_pkg::VAL_W-1:0]  new_value,
  input  wire  [svau_pkg::IT_W-1:0]          iteration,
  // result beats
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [svau_pkg::IDX_W-1:0]         result_index,
  output logic signed [svau_pkg::VAL_W-1:0]  result_value,
  output logic                               accelerated,
  output logic                               saturated
);

  localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int VW = svau_pkg::VAL_W;
  localparam int XW = svau_pkg::DIFF_W;
  localparam int DW = svau_pkg::DEN_W;
  localparam int IW = svau_pkg::IDX_W;
  localparam int PW = svau_pkg::PROD_W;
  localparam int LW = XW + 16;            // |a| * low half of |b|
  localparam int HW = PW - 16;            // |a| * high part of |b|

  // ---------------- configuration ----------------
  logic [svau_pkg::IT_W-1:0]  start_iteration;
  logic [svau_pkg::THR_W-1:0] difference_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_iteration      <= svau_pkg::START_ITERATION_RST;
      difference_threshold <= svau_pkg::DIFF_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        svau_pkg::CFG_START_ITERATION: start_iteration <= cfg_data[svau_pkg::IT_W-1:0];
        svau_pkg::CFG_DIFF_THRESHOLD:  difference_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage types ----------------
  typedef struct packed {
    logic [IW-1:0] idx;
    logic [VW-1:0] nv;
    logic          inr;     // index inside the vector
    logic          trig;    // trigger iteration
    logic          fwd;     // history came from the beat just written
    logic [VW-1:0] fp1;
    logic [VW-1:0] fp2;
  } s1_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [VW-1:0] nv;
    logic [VW-1:0] p1;
    logic          elig;
    logic [XW-1:0] a;
    logic [XW-1:0] b;
    logic [DW-1:0] d;
  } s2_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [VW-1:0] nv;
    logic [VW-1:0] p1;
    logic          elig;
    logic [XW-1:0] ua;
    logic [XW-1:0] ub;
    logic [DW-1:0] md;
    logic          num_neg;
    logic          neg;
    logic          dz;
  } s3_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [VW-1:0] nv;
    logic [VW-1:0] p1;
    logic          acc;
    logic [DW-1:0] md;
    logic          num_neg;
    logic          neg;
    logic          dz;
    logic [LW-1:0] pp_lo;
    logic [HW-1:0] pp_hi;
  } s4_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [VW-1:0] nv;
    logic [VW-1:0] p1;
    logic          acc;
    logic [DW-1:0] md;
    logic          num_neg;
    logic          neg;
    logic          dz;
    logic [PW-1:0] prod;
  } s5_t;

  typedef struct packed {
    svau_pkg::side_t side;
    logic [PW-1:0]   prod;
    logic [DW-1:0]   md;
  } s6_t;

  s1_t s1; s2_t s2; s3_t s3; s4_t s4; s5_t s5; s6_t s6;
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic div_in_stall;

  assign en6 = ~v6 | ~div_in_stall;
  assign en5 = ~v5 | en6;
  assign en4 = ~v4 | en5;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;

  // ---------------- history memory and post-reset sweep ----------------
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          accept;
  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic [2*VW-1:0] hist_wdata;
  logic [2*VW-1:0] hist_rdata;
  logic          wr_beat;     // beat in S1 updates its history this edge
  logic [VW-1:0] p1_res, p2_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(VECTOR_LENGTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign in_stall = clearing | ~en1;
  assign accept   = in_valid & ~in_stall;

  // Apart from the sweep, S1 owns the only history write; the newest value moves into p1, p1 into p2
  assign p1_res  = s1.fwd ? s1.fp1 : hist_rdata[2*VW-1:VW];
  assign p2_res  = s1.fwd ? s1.fp2 : hist_rdata[VW-1:0];
  assign wr_beat = v1 & en2 & s1.inr;

  assign hist_we    = clearing | wr_beat;
  assign hist_waddr = clearing ? clr_cnt : AW'(s1.idx);
  assign hist_wdata = clearing ? '0 : {s1.nv, p1_res};

  svau_ram #(
    .WIDTH (2 * VW),
    .DEPTH (VECTOR_LENGTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (accept),
    .raddr (AW'(element_index)),
    .rdata (hist_rdata)
  );

  // ---------------- S1: capture beat, catch the write the read misses ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1.idx  <= element_index;
      s1.nv   <= new_value;
      s1.inr  <= 32'(element_index) < 32'(VECTOR_LENGTH);
      s1.trig <= (iteration >= start_iteration) && (iteration[0] == start_iteration[0]);
      s1.fwd  <= wr_beat && (s1.idx == element_index);
      s1.fp1  <= s1.nv;
      s1.fp2  <= p1_res;
    end
  end

  // ---------------- S2: differences ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2.idx  <= s1.idx;
      s2.nv   <= s1.nv;
      s2.p1   <= p1_res;
      s2.elig <= s1.inr & s1.trig;
      s2.a    <= {s1.nv[VW-1], s1.nv} - {p1_res[VW-1], p1_res};
      s2.b    <= {p1_res[VW-1], p1_res} - {p2_res[VW-1], p2_res};
      // b - a = 2*p1 - p2 - nv
      s2.d    <= {p1_res[VW-1], p1_res, 1'b0} - {{2{p2_res[VW-1]}}, p2_res}
               - {{2{s1.nv[VW-1]}}, s1.nv};
    end
  end

  // ---------------- S3: magnitudes and signs ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3.idx     <= s2.idx;
      s3.nv      <= s2.nv;
      s3.p1      <= s2.p1;
      s3.elig    <= s2.elig;
      s3.ua      <= s2.a[XW-1] ? (~s2.a + 1'b1) : s2.a;
      s3.ub      <= s2.b[XW-1] ? (~s2.b + 1'b1) : s2.b;
      s3.md      <= s2.d[DW-1] ? (~s2.d + 1'b1) : s2.d;
      s3.num_neg <= s2.a[XW-1] ^ s2.b[XW-1];
      s3.neg     <= s2.a[XW-1] ^ s2.b[XW-1] ^ s2.d[DW-1];
      s3.dz      <= (s2.d == '0);
    end
  end

  // ---------------- S4: threshold test, partial products ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4.idx     <= s3.idx;
      s4.nv      <= s3.nv;
      s4.p1      <= s3.p1;
      s4.acc     <= s3.elig && (s3.ua > {2'b00, difference_threshold})
                            && (s3.ub > {2'b00, difference_threshold});
      s4.md      <= s3.md;
      s4.num_neg <= s3.num_neg;
      s4.neg     <= s3.neg;
      s4.dz      <= s3.dz;
      s4.pp_lo   <= LW'(s3.ua) * LW'(s3.ub[15:0]);
      s4.pp_hi   <= HW'(s3.ua) * HW'(s3.ub[XW-1:16]);
    end
  end

  // ---------------- S5: full product ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5.idx     <= s4.idx;
      s5.nv      <= s4.nv;
      s5.p1      <= s4.p1;
      s5.acc     <= s4.acc;
      s5.md      <= s4.md;
      s5.num_neg <= s4.num_neg;
      s5.neg     <= s4.neg;
      s5.dz      <= s4.dz;
      s5.prod    <= PW'(s4.pp_lo) + {s4.pp_hi, 16'b0};
    end
  end

  // ---------------- S6: quotient overflow and zero-denominator cases ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6.side.idx       <= s5.idx;
      s6.side.nv        <= s5.nv;
      s6.side.p1        <= s5.p1;
      s6.side.acc       <= s5.acc;
      // quotient needs more than 33 bits iff prod >> 33 >= |d|
      s6.side.early_sat <= s5.acc & (s5.dz | ({2'b00, s5.prod[PW-1:svau_pkg::QUO_W]} >= s5.md));
      s6.side.early_neg <= s5.dz ? s5.num_neg : s5.neg;
      s6.side.neg       <= s5.neg;
      s6.prod           <= s5.prod;
      s6.md             <= s5.md;
    end
  end

  // ---------------- divider ----------------
  logic                       div_out_valid;
  logic                       div_out_stall;
  logic [svau_pkg::QUO_W-1:0] div_q;
  svau_pkg::side_t            div_side;

  svau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_stall  (div_in_stall),
    .in_num    (s6.prod),
    .in_den    (s6.md),
    .in_side   (s6.side),
    .out_valid (div_out_valid),
    .out_stall (div_out_stall),
    .out_q     (div_q),
    .out_side  (div_side)
  );

  // ---------------- output stage: p1 +/- quotient, saturate, or pass nv ----------------
  logic                       out_en;
  logic [svau_pkg::SUM_W-1:0] sum;
  logic [VW-1:0]              res_next;
  logic                       sat_next;

  assign out_en        = ~out_valid | ~out_stall;
  assign div_out_stall = ~out_en;

  always_comb begin
    sum = div_side.neg
        ? {{3{div_side.p1[VW-1]}}, div_side.p1} - {2'b00, div_q}
        : {{3{div_side.p1[VW-1]}}, div_side.p1} + {2'b00, div_q};
    res_next = div_side.nv;
    sat_next = 1'b0;
    if (div_side.acc) begin
      if (div_side.early_sat) begin
        sat_next = 1'b1;
        res_next = div_side.early_neg ? svau_pkg::Q_MIN : svau_pkg::Q_MAX;
      end else if (sum[svau_pkg::SUM_W-1:VW-1] != {4{sum[svau_pkg::SUM_W-1]}}) begin
        sat_next = 1'b1;
        res_next = sum[svau_pkg::SUM_W-1] ? svau_pkg::Q_MIN : svau_pkg::Q_MAX;
      end else begin
        res_next = sum[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result_index <= div_side.idx;
      result_value <= res_next;
      accelerated  <= div_side.acc;
      saturated    <= sat_next;
    end
  end

  `SVAU_ASSERT_NOW(a_sat_acc, out_valid && saturated, accelerated, "saturated without acceleration")
  `SVAU_ASSERT_NOW(a_acc_range, out_valid && accelerated, 32'(result_index) < 32'(VECTOR_LENGTH), "accelerated beat outside vector")
  `SVAU_ASSERT_NOW(a_no_take_clr, in_valid && !in_stall, !clearing, "beat taken during history sweep")

endmodule
`default_nettype wire
